FILE: rtl/lci_pkg.sv
// ----------------------------------------------------------------------------
// lci_pkg
// Shared widths, codes and payload types of the lattice cell index block.
// ----------------------------------------------------------------------------
package lci_pkg;

  localparam int COORD_BITS = 32;
  localparam int PITCH_BITS = 32;
  localparam int INDEX_BITS = 16;
  // working fraction of the scaled coordinates
  localparam int WF         = 16;
  // fraction part of sqrt(3) in 2^-16 units
  localparam int SQRT3_FRAC = 47976;

  typedef enum logic [1:0] {
    KIND_SQUARE = 2'd0,
    KIND_TRI_X  = 2'd1,
    KIND_HEX_X  = 2'd2,
    KIND_HEX_Y  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_INV_PITCH_X  = 2'd0,
    REG_INV_PITCH_Y  = 2'd1,
    REG_INV_PITCH_Z  = 2'd2,
    REG_LATTICE_KIND = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } coord_t;

  typedef struct packed {
    logic signed [INDEX_BITS-1:0] index_i;
    logic signed [INDEX_BITS-1:0] index_j;
    logic signed [INDEX_BITS-1:0] index_k;
  } index_t;

endpackage

FILE: rtl/lci_div3.sv
// ----------------------------------------------------------------------------
// lci_div3
// Pipelined two-lane unsigned divide by three, eight dividend bits per stage,
// with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module lci_div3 #(
  parameter int YB     = 19,
  parameter int SIDE_W = 49
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0][YB-1:0]   dividend_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0][YB-1:0]   quotient_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int STEP = 8;
  localparam int NS   = (YB + STEP - 1) / STEP;

  // each lane word starts as the dividend; processed bits become quotient bits
  logic [1:0][YB-1:0] w_q    [NS];
  logic [1:0][1:0]    r_q    [NS];
  logic [SIDE_W-1:0]  side_q [NS];
  logic               v_q    [NS];
  logic               en     [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [1:0][YB-1:0] w_in;
    logic [1:0][1:0]    r_in;
    logic [SIDE_W-1:0]  side_in;
    logic               v_in;
    logic [1:0][YB-1:0] w_d;
    logic [1:0][1:0]    r_d;

    if (s == 0) begin : g_first
      assign w_in    = dividend_i;
      assign r_in    = '0;
      assign side_in = side_i;
      assign v_in    = in_valid_i;
    end else begin : g_next
      assign w_in    = w_q[s-1];
      assign r_in    = r_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = v_q[s-1];
    end

    if (s == NS - 1) begin : g_last
      assign en[s] = !v_q[s] || out_ready_i;
    end else begin : g_mid
      assign en[s] = !v_q[s] || en[s+1];
    end

    always_comb begin
      logic [2:0] t;
      w_d = w_in;
      r_d = r_in;
      t   = '0;
      for (int l = 0; l < 2; l++) begin
        for (int b = 0; b < STEP; b++) begin
          if (YB - 1 - s * STEP - b >= 0) begin
            t = {r_d[l], w_d[l][YB-1-s*STEP-b]};
            if (t >= 3'd3) begin
              w_d[l][YB-1-s*STEP-b] = 1'b1;
              r_d[l] = 2'(t - 3'd3);
            end else begin
              w_d[l][YB-1-s*STEP-b] = 1'b0;
              r_d[l] = t[1:0];
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        w_q[s]    <= w_d;
        r_q[s]    <= r_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign quotient_o  = w_q[NS-1];
  assign side_o      = side_q[NS-1];

endmodule

FILE: rtl/lattice_cell_index.sv
// ----------------------------------------------------------------------------
// lattice_cell_index
// Maps a fixed-point point to square, triangular or hexagonal cell indices.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    coord_t  (coord_x, coord_y, coord_z)
//  out       output     out_valid/out_ready  index_t  (index_i, index_j, index_k)
//  config    input      APB, pready tied 1   inv_pitch_x/y/z, lattice_kind
//
// One point enters per cycle while the pipe is not stalled; the stages in order
// are product, sqrt(3) product, rounding and sums, hexagonal rounding, clamp,
// the divide-by-three stages, and the output register.
// Each stage holds its item only while the stage after it is full and stalled,
// so bubbles close up and a stalled output does not block intake until the
// pipe is full. Reset empties the pipe and loads the default registers.
module lattice_cell_index
  import lci_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  coord_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output index_t      out_data_o
);

  localparam int PW = COORD_BITS + PITCH_BITS + 2;  // raw product
  localparam int SW = PW - FRAC_BITS;               // scaled coordinate
  localparam int KW = 17;                           // sqrt(3) fraction operand
  localparam int HW = SW + KW;                      // sqrt(3) product
  localparam int NW = SW + 3;                       // projections
  localparam int DW = NW + 1;                       // differences
  localparam int YB = INDEX_BITS + 3;               // divider operand
  localparam int UW = WF + 1;

  localparam logic signed [KW-1:0] SQRT3_K = KW'(SQRT3_FRAC);
  localparam logic signed [NW-1:0] HALF_N  = NW'(1) <<< (WF - 1);
  localparam logic signed [DW-1:0] SAT_HI  = (DW'(1) <<< (INDEX_BITS - 1)) - DW'(1);
  localparam logic signed [DW-1:0] SAT_LO  = -SAT_HI - DW'(1);
  localparam logic signed [DW-1:0] CLP_HI  = SAT_HI * DW'(3) + DW'(3);
  localparam logic signed [DW-1:0] CLP_LO  = SAT_LO * DW'(3) - DW'(3);
  localparam logic signed [DW-1:0] DIV_OFS = DW'(3) <<< INDEX_BITS;
  localparam logic signed [DW-1:0] Q_OFS   = DW'(1) <<< INDEX_BITS;

  typedef struct packed {
    logic                         hex;
    logic signed [INDEX_BITS-1:0] byp_i;
    logic signed [INDEX_BITS-1:0] byp_j;
    logic signed [INDEX_BITS-1:0] idx_k;
  } side_t;

  function automatic logic signed [NW-1:0] rnd_even(input logic signed [NW-1:0] s);
    logic signed [NW-1:0] ip;
    logic                 up;
    ip = s >>> WF;
    // above half, or exactly half with an odd integer part
    up = s[WF-1] & ((|s[WF-2:0]) | ip[0]);
    return ip + {{(NW-1){1'b0}}, up};
  endfunction

  function automatic logic signed [INDEX_BITS-1:0] sat_idx(input logic signed [DW-1:0] v);
    logic signed [INDEX_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[INDEX_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[INDEX_BITS-1:0];
    end else begin
      r = v[INDEX_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [YB-1:0] div_operand(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] c;
    if (v > CLP_HI) begin
      c = CLP_HI;
    end else if (v < CLP_LO) begin
      c = CLP_LO;
    end else begin
      c = v;
    end
    // shift by a multiple of three so the divider sees a nonnegative value
    c = c + DIV_OFS;
    return c[YB-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [PITCH_BITS-1:0] inv_x_q, inv_y_q, inv_z_q;
  kind_e                 kind_q;
  logic                  cfg_wr;
  reg_idx_e              reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= PITCH_BITS'(65536);
      inv_y_q <= PITCH_BITS'(65536);
      inv_z_q <= PITCH_BITS'(65536);
      kind_q  <= KIND_SQUARE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INV_PITCH_X:  inv_x_q <= pwdata;
        REG_INV_PITCH_Y:  inv_y_q <= pwdata;
        REG_INV_PITCH_Z:  inv_z_q <= pwdata;
        REG_LATTICE_KIND: kind_q  <= kind_e'(pwdata[1:0]);
        default:          kind_q  <= kind_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INV_PITCH_X:  prdata = inv_x_q;
      REG_INV_PITCH_Y:  prdata = inv_y_q;
      REG_INV_PITCH_Z:  prdata = inv_z_q;
      REG_LATTICE_KIND: prdata = {30'd0, kind_q};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // stage valids and advance enables
  // --------------------------------------------------------------------------
  logic [5:1] v_q;
  logic [5:1] en;
  logic       div_ready, div_valid, out_en;

  assign en[5]      = !v_q[5] || div_ready;
  assign en[4]      = !v_q[4] || en[5];
  assign en[3]      = !v_q[3] || en[4];
  assign en[2]      = !v_q[2] || en[3];
  assign en[1]      = !v_q[1] || en[2];
  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
      if (en[5]) v_q[5] <= v_q[4];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: coordinate times reciprocal pitch
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] px_q, py_q, pz_q;
  kind_e                kind1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      px_q    <= $signed({in_data_i.coord_x[COORD_BITS-1], in_data_i.coord_x})
               * $signed({1'b0, inv_x_q});
      py_q    <= $signed({in_data_i.coord_y[COORD_BITS-1], in_data_i.coord_y})
               * $signed({1'b0, inv_y_q});
      pz_q    <= $signed({in_data_i.coord_z[COORD_BITS-1], in_data_i.coord_z})
               * $signed({1'b0, inv_z_q});
      kind1_q <= kind_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: floor to the working fraction, hexagonal axis swap, sqrt(3) term
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sx_d, sy_d, sz_d, hx_d, hy_d;
  logic signed [HW-1:0] hp_d;
  logic signed [SW-1:0] sx2_q, sy2_q, sz2_q, hx2_q, hy2_q;
  logic signed [HW-1:0] hp2_q;
  kind_e                kind2_q;

  assign sx_d = $signed(px_q[PW-1:FRAC_BITS]);
  assign sy_d = $signed(py_q[PW-1:FRAC_BITS]);
  assign sz_d = $signed(pz_q[PW-1:FRAC_BITS]);
  assign hx_d = (kind1_q == KIND_HEX_Y) ? sy_d : sx_d;
  assign hy_d = (kind1_q == KIND_HEX_Y) ? sx_d : sy_d;
  assign hp_d = hy_d * SQRT3_K;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sx2_q   <= sx_d;
      sy2_q   <= sy_d;
      sz2_q   <= sz_d;
      hx2_q   <= hx_d;
      hy2_q   <= hy_d;
      hp2_q   <= hp_d;
      kind2_q <= kind1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: square and triangular indices, hexagonal projections
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] a1_d, a2_d, a3_d, k_d;
  logic signed [NW-1:0] a1_q, a2_q, a3_q, k3_q;
  logic                 hex3_q;
  logic signed [NW-1:0] ti, tj, hx_n, ry;
  logic [WF-1:0]        fu, fv;
  logic [UW-1:0]        uv_sum;
  logic                 tri_inc;

  assign ti     = NW'($signed(sx2_q[SW-1:WF]));
  assign tj     = NW'($signed(sy2_q[SW-1:WF]));
  assign fu     = sx2_q[WF-1:0];
  assign fv     = sy2_q[WF-1:0];
  assign uv_sum = {1'b0, fu} + {1'b0, fv};
  // odd parity of i + j takes the falling diagonal, even the rising one
  assign tri_inc = (ti[0] ^ tj[0]) ? (uv_sum > (UW'(1) << WF)) : (fv > fu);
  assign hx_n   = NW'(hx2_q);
  assign ry     = NW'(hy2_q) + NW'($signed(hp2_q[HW-1:WF]));
  assign k_d    = rnd_even(NW'(sz2_q));

  always_comb begin
    case (kind2_q)
      KIND_SQUARE: begin
        a1_d = rnd_even(NW'(sx2_q));
        a2_d = rnd_even(NW'(sy2_q));
        a3_d = '0;
      end
      KIND_TRI_X: begin
        a1_d = ti;
        a2_d = tj + {{(NW-1){1'b0}}, tri_inc};
        a3_d = '0;
      end
      default: begin
        a1_d = (hx_n <<< 1) - HALF_N;
        a2_d = ry - hx_n - HALF_N;
        a3_d = -hx_n - ry - HALF_N;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      a1_q   <= a1_d;
      a2_q   <= a2_d;
      a3_q   <= a3_d;
      k3_q   <= k_d;
      hex3_q <= (kind2_q == KIND_HEX_X) || (kind2_q == KIND_HEX_Y);
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: round the hexagonal projections
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] b1_q, b2_q, b3_q, k4_q;
  logic                 hex4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      b1_q   <= hex3_q ? rnd_even(a1_q) : a1_q;
      b2_q   <= hex3_q ? rnd_even(a2_q) : a2_q;
      b3_q   <= hex3_q ? rnd_even(a3_q) : a3_q;
      k4_q   <= k3_q;
      hex4_q <= hex3_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: differences clamped into divider range, saturated bypass values
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] di, dj;
  logic [1:0][YB-1:0]   y5_q;
  side_t                side5_q;

  // floor((2d + 3) / 6) equals floor((d + 1) / 3)
  assign di = DW'(b1_q) - DW'(b2_q) + DW'(1);
  assign dj = DW'(b2_q) - DW'(b3_q) + DW'(1);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      y5_q[0]       <= div_operand(di);
      y5_q[1]       <= div_operand(dj);
      side5_q.hex   <= hex4_q;
      side5_q.byp_i <= sat_idx(DW'(b1_q));
      side5_q.byp_j <= sat_idx(DW'(b2_q));
      side5_q.idx_k <= sat_idx(DW'(k4_q));
    end
  end

  // --------------------------------------------------------------------------
  // divide by three
  // --------------------------------------------------------------------------
  logic [1:0][YB-1:0]  div_q;
  logic [$bits(side_t)-1:0] div_side;
  side_t               side_o;

  lci_div3 #(
    .YB     (YB),
    .SIDE_W ($bits(side_t))
  ) u_div3 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[5]),
    .in_ready_o  (div_ready),
    .dividend_i  (y5_q),
    .side_i      (side5_q),
    .out_valid_o (div_valid),
    .out_ready_i (out_en),
    .quotient_o  (div_q),
    .side_o      (div_side)
  );

  assign side_o = side_t'(div_side);

  // --------------------------------------------------------------------------
  // output register: pass the bypass values, or remove the divider offset and saturate
  // --------------------------------------------------------------------------
  logic                 ov_q;
  index_t               out_q, out_d;
  logic signed [DW-1:0] qi, qj;

  assign out_en = !ov_q || out_ready_i;
  assign qi     = $signed(DW'(div_q[0])) - Q_OFS;
  assign qj     = $signed(DW'(div_q[1])) - Q_OFS;

  always_comb begin
    out_d.index_i = side_o.hex ? sat_idx(qi) : side_o.byp_i;
    out_d.index_j = side_o.hex ? sat_idx(qj) : side_o.byp_j;
    out_d.index_k = side_o.idx_k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_en) begin
      ov_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lattice_cell_index. Streams points through the block
// under every lattice kind and several pitch settings, predicts each cell index
// in fixed point, and checks the results in order with random flow control.
// ----------------------------------------------------------------------------
module tb;
  import lci_pkg::*;

  localparam int FRAC_BITS        = 16;
  localparam int ONE_W            = 1 << WF;
  localparam int HALF_W           = 1 << (WF - 1);
  localparam int DRAIN_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int LONG_HOLD        = 300;
  localparam int RANDOM_PHASES    = 12;
  localparam int POINTS_PER_PHASE = 100;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  coord_t      in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  index_t      out_data_o;

  lattice_cell_index #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  // shadow copy of the configuration registers
  logic [31:0] pitch_x_q = 32'd65536;
  logic [31:0] pitch_y_q = 32'd65536;
  logic [31:0] pitch_z_q = 32'd65536;
  kind_e       kind_q    = KIND_SQUARE;

  coord_t pending_points[$];
  index_t expected_cells[$];

  int   mismatches     = 0;
  int   points_done    = 0;
  int   cells_checked  = 0;
  int   settings_used  = 0;
  int   idle_cycles    = 0;
  int   gap_left       = 0;
  int   stall_left     = 0;
  int   hold_left      = 0;
  logic in_took        = 1'b0;
  bit   idle_enable    = 1'b0;
  bit   stall_enable   = 1'b0;
  bit   hold_request   = 1'b0;
  bit   hold_served    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Cell index prediction
  // --------------------------------------------------------------------------
  function automatic longint scaled(logic signed [31:0] c, logic [31:0] inv);
    longint iv;
    iv = longint'(inv);
    return (longint'(c) * iv) >>> FRAC_BITS;
  endfunction

  function automatic longint round_half_even(longint s);
    longint ip;
    longint fr;
    ip = s >>> WF;
    fr = s - (ip <<< WF);
    if (fr > HALF_W || (fr == HALF_W && ip[0])) ip = ip + 1;
    return ip;
  endfunction

  // floor(1/2 + d/3), done exactly as floor((2d + 3) / 6)
  function automatic longint nearest_third(longint d);
    longint a;
    longint q;
    a = 2 * d + 3;
    q = a / 6;
    if (a % 6 != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [INDEX_BITS-1:0] clamp_index(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (INDEX_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[INDEX_BITS-1:0];
  endfunction

  function automatic index_t cell_of(coord_t c);
    longint sx, sy, sz, hx, hy, ry, ci, cj, u, v, m1, m2, m3;
    index_t r;
    sx = scaled(c.coord_x, pitch_x_q);
    sy = scaled(c.coord_y, pitch_y_q);
    sz = scaled(c.coord_z, pitch_z_q);
    case (kind_q)
      KIND_SQUARE: begin
        ci = round_half_even(sx);
        cj = round_half_even(sy);
      end
      KIND_TRI_X: begin
        ci = sx >>> WF;
        cj = sy >>> WF;
        u  = sx - (ci <<< WF);
        v  = sy - (cj <<< WF);
        // odd i + j splits on the falling diagonal, even on the rising one
        if (ci[0] ^ cj[0]) begin
          if (u + v > ONE_W) cj = cj + 1;
        end else if (v > u) begin
          cj = cj + 1;
        end
      end
      default: begin
        hx = (kind_q == KIND_HEX_Y) ? sy : sx;
        hy = (kind_q == KIND_HEX_Y) ? sx : sy;
        ry = hy + ((hy * SQRT3_FRAC) >>> WF);
        m1 = round_half_even(2 * hx - HALF_W);
        m2 = round_half_even(ry - hx - HALF_W);
        m3 = round_half_even(-hx - ry - HALF_W);
        ci = nearest_third(m1 - m2);
        cj = nearest_third(m2 - m3);
      end
    endcase
    r.index_i = clamp_index(ci);
    r.index_j = clamp_index(cj);
    r.index_k = clamp_index(round_half_even(sz));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             cells_checked);
  endtask

  // --------------------------------------------------------------------------
  // Sender: hold the point until the transfer, then advance or idle a burst
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (idle_enable && pending_points.size() > 0 && $urandom_range(0, 5) == 0) begin
        gap_left   = $urandom_range(1, 8) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_points.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_points.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: one long hold on request, otherwise short random stalls
  always @(negedge clk_i) begin
    if (hold_request && !hold_served) begin
      hold_served = 1'b1;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_enable && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(1, 8) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin
    index_t want;
    logic   in_fire;
    logic   out_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    in_took <= in_fire;
    if (out_fire) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("result with no point pending", out_data_o.index_i, 0);
      end else begin
        want = expected_cells.pop_front();
        if (out_data_o.index_i !== want.index_i)
          report_mismatch("index_i", out_data_o.index_i, want.index_i);
        if (out_data_o.index_j !== want.index_j)
          report_mismatch("index_j", out_data_o.index_j, want.index_j);
        if (out_data_o.index_k !== want.index_k)
          report_mismatch("index_k", out_data_o.index_k, want.index_k);
        cells_checked++;
      end
    end
    if (in_fire) begin
      expected_cells.push_back(cell_of(in_data_i));
      points_done++;
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("lattice_cell_index test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INV_PITCH_X:  pitch_x_q = val;
      REG_INV_PITCH_Y:  pitch_y_q = val;
      REG_INV_PITCH_Z:  pitch_z_q = val;
      REG_LATTICE_KIND: kind_q    = kind_e'(val[1:0]);
      default:          ;
    endcase
  endtask

  task automatic set_lattice(kind_e kind, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz);
    write_reg(REG_INV_PITCH_X, px);
    write_reg(REG_INV_PITCH_Y, py);
    write_reg(REG_INV_PITCH_Z, pz);
    write_reg(REG_LATTICE_KIND, {30'b0, kind});
    settings_used++;
  endtask

  task automatic push_point(int x, int y, int z);
    coord_t p;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    pending_points.push_back(p);
  endtask

  // wait out every pending point and result, then let the pipe settle
  task automatic drain();
    while (pending_points.size() > 0 || in_valid_i || expected_cells.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int random_coord();
    int whole;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
      4, 5: begin
        // land on quarter and half cell boundaries
        whole = $urandom_range(0, 100) - 50;
        return whole * ONE_W + $urandom_range(0, 3) * (ONE_W / 4);
      end
      6: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      7: return int'($urandom) >>> $urandom_range(1, 12);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_pitch(bit wild);
    if (!wild) return $urandom_range(32'h2000, 32'h8_0000);
    case ($urandom_range(0, 5))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      3: return ONE_W;
      4: return $urandom_range(32'h2000, 32'h8_0000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // square: extremes, saturation and round-half-even ties
    set_lattice(KIND_SQUARE, ONE_W, ONE_W, ONE_W);
    push_point(0, 0, 0);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_point(32'h0000_8000, 32'h0001_8000, -32768);
    push_point(-98304, 32'h0002_8000, 32'h0000_7FFF);
    drain();

    // largest, smallest and zero reciprocal pitch
    set_lattice(KIND_SQUARE, 32'hFFFF_FFFF, 32'd1, 32'd0);
    push_point(32'h0001_2345, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_point(-1, 32'h8000_0000, 32'h8000_0000);
    drain();

    // triangular: both diagonal slopes, negative parity, exact diagonal
    set_lattice(KIND_TRI_X, ONE_W, ONE_W, ONE_W);
    push_point(32'h0000_4000, 32'h0000_8000, 32'h0001_8000);
    push_point(32'h0000_8000, 32'h0000_4000, 32'h0002_8000);
    push_point(32'h0001_C000, 32'h0000_C000, 0);
    push_point(32'h0001_4000, 32'h0000_4000, 0);
    push_point(-16384, -32768, -98304);
    push_point(-81920, -49152, 0);
    drain();

    set_lattice(KIND_HEX_X, ONE_W, ONE_W, ONE_W);
    push_point(0, 0, 0);
    push_point(32'h0001_0000, 32'h0000_8000, 0);
    push_point(-196608, 32'h0001_BB67, 32'h0002_8000);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    drain();

    set_lattice(KIND_HEX_Y, ONE_W, ONE_W, ONE_W);
    push_point(32'h0000_8000, 32'h0001_0000, 0);
    push_point(-74565, 32'h0005_4321, -32768);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // no idling in the closing phases
      idle_enable  = (ph % 3 != 2) && (ph < RANDOM_PHASES - 2);
      stall_enable = idle_enable;
      case (ph / 4)
        0: set_lattice(kind_e'(ph % 4), ONE_W, ONE_W, ONE_W);
        1: set_lattice(kind_e'(ph % 4), pick_pitch(1'b0), pick_pitch(1'b0),
                       pick_pitch(1'b0));
        default: set_lattice(kind_e'(ph % 4), pick_pitch(1'b1), pick_pitch(1'b1),
                             pick_pitch(1'b1));
      endcase
      repeat (POINTS_PER_PHASE) push_point(random_coord(), random_coord(), random_coord());
      // back up the pipe while the sender keeps offering points
      if (ph == 5) hold_request = 1'b1;
      drain();
    end

    $display("Checked %0d results from %0d points over %0d lattice settings.",
             cells_checked, points_done, settings_used);
    $display("All four lattice kinds, unit, scaled and extreme pitches, one long stall.");
    if (mismatches == 0) begin
      $display("lattice_cell_index test passed");
    end else begin
      $display("lattice_cell_index test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lci_pkg.sv
rtl/lci_div3.sv
rtl/lattice_cell_index.sv
tb/tb.sv
